@@ sv/bfi_pkg.sv @@
// Shared types, sizes and codes for the brainfuck interpreter core.
// No dependencies.
`default_nettype none
package bfi_pkg;

  localparam int PROG_DEPTH = 256;
  localparam int PROG_AW    = $clog2(PROG_DEPTH);
  localparam int PROG_CW    = $clog2(PROG_DEPTH + 1);
  localparam int TAPE_CELLS = 128;
  localparam int TAPE_AW    = $clog2(TAPE_CELLS);
  localparam int IN_DEPTH   = 64;
  localparam int IN_AW      = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
  localparam int IN_CW      = $clog2(IN_DEPTH + 1);
  localparam int OUT_MAX    = 64;
  localparam int OUT_CW     = $clog2(OUT_MAX + 1);

  localparam logic [1:0] FN_LOAD_PROG = 2'd0;
  localparam logic [1:0] FN_LOAD_IN   = 2'd1;
  localparam logic [1:0] FN_RUN       = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_STEPS   = 2'd2;
  localparam logic [1:0] ST_BRACKET = 2'd3;

  localparam logic [7:0] CHR_RIGHT = 8'h3E;
  localparam logic [7:0] CHR_LEFT  = 8'h3C;
  localparam logic [7:0] CHR_INC   = 8'h2B;
  localparam logic [7:0] CHR_DEC   = 8'h2D;
  localparam logic [7:0] CHR_OUT   = 8'h2E;
  localparam logic [7:0] CHR_IN    = 8'h2C;
  localparam logic [7:0] CHR_OPEN  = 8'h5B;
  localparam logic [7:0] CHR_CLOSE = 8'h5D;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_EXEC, S_SF_RD, S_SF_CHK, S_SB_RD, S_SB_CHK, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_START, OP_FETCH, OP_EXEC,
    OP_SF_RD, OP_SF_CHK, OP_SB_RD, OP_SB_CHK, OP_FINISH
  } op_t;

  typedef enum logic [3:0] {
    CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_OUT, CH_IN, CH_OPEN, CH_CLOSE, CH_OTHER
  } ch_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    ch_t  cls;
    logic cell_zero;
    logic pc_end;
    logic steps_hit;
    logic out_full;
    logic depth_zero;
    logic q_end;
    logic q_zero;
  } sts_t;

  function automatic ch_t classify(input logic [7:0] c);
    ch_t r;
    case (c)
      CHR_RIGHT: r = CH_RIGHT;
      CHR_LEFT:  r = CH_LEFT;
      CHR_INC:   r = CH_INC;
      CHR_DEC:   r = CH_DEC;
      CHR_OUT:   r = CH_OUT;
      CHR_IN:    r = CH_IN;
      CHR_OPEN:  r = CH_OPEN;
      CHR_CLOSE: r = CH_CLOSE;
      default:   r = CH_OTHER;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/bfi_ctrl.sv @@
// Sequencer for the interpreter: load, fetch/execute and bracket scans.
// Depends on bfi_pkg.
`default_nettype none
module bfi_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [1:0]    func,
  input  wire bfi_pkg::sts_t sts,
  output bfi_pkg::cmd_t      cmd,
  output logic               busy
);
  import bfi_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (start && func == FN_RUN) begin
          state_nxt  = S_FETCH;
          status_nxt = ST_OK;
        end
      end
      S_FETCH: begin
        state_nxt = sts.pc_end ? S_DONE : S_EXEC;
      end
      S_EXEC: begin
        if (sts.steps_hit) begin
          state_nxt  = S_DONE;
          status_nxt = ST_STEPS;
        end else if (sts.cls == CH_OUT && sts.out_full) begin
          state_nxt  = S_DONE;
          status_nxt = ST_TRUNC;
        end else if (sts.cls == CH_OPEN && sts.cell_zero) begin
          state_nxt = S_SF_RD;
        end else if (sts.cls == CH_CLOSE && !sts.cell_zero) begin
          state_nxt = S_SB_RD;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_SF_RD: begin
        if (sts.q_end) begin
          state_nxt  = S_DONE;
          status_nxt = ST_BRACKET;
        end else begin
          state_nxt = S_SF_CHK;
        end
      end
      S_SF_CHK: begin
        state_nxt = (sts.cls == CH_CLOSE && sts.depth_zero) ? S_FETCH : S_SF_RD;
      end
      S_SB_RD: begin
        if (sts.q_zero) begin
          state_nxt  = S_DONE;
          status_nxt = ST_BRACKET;
        end else begin
          state_nxt = S_SB_CHK;
        end
      end
      S_SB_CHK: begin
        state_nxt = (sts.cls == CH_OPEN && sts.depth_zero) ? S_FETCH : S_SB_RD;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.op     = OP_NONE;
    cmd.status = status_r;
    busy       = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (func == FN_RUN) begin
            cmd.op = OP_START;
          end else if (func == FN_LOAD_PROG || func == FN_LOAD_IN) begin
            cmd.op = OP_LOAD;
          end
        end
      end
      S_FETCH: begin
        if (!sts.pc_end) begin
          cmd.op = OP_FETCH;
        end
      end
      S_EXEC: begin
        if (!sts.steps_hit && !(sts.cls == CH_OUT && sts.out_full)) begin
          cmd.op = OP_EXEC;
        end
      end
      S_SF_RD: begin
        if (!sts.q_end) begin
          cmd.op = OP_SF_RD;
        end
      end
      S_SF_CHK: cmd.op = OP_SF_CHK;
      S_SB_RD: begin
        if (!sts.q_zero) begin
          cmd.op = OP_SB_RD;
        end
      end
      S_SB_CHK: cmd.op = OP_SB_CHK;
      S_DONE:   cmd.op = OP_FINISH;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/bfi_datapath.sv @@
// Stores, tape, pointers, counters and result register of the interpreter.
// Depends on bfi_pkg; driven by bfi_ctrl commands.
`default_nettype none
module bfi_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bfi_pkg::cmd_t cmd,
  input  wire logic [1:0]    func,
  input  wire logic [7:0]    data_byte,
  input  wire logic [31:0]   step_limit,
  output bfi_pkg::sts_t      sts,
  output logic               out_strobe,
  output logic               out_has_byte,
  output logic [7:0]         out_out_byte,
  output logic               out_last,
  output logic [1:0]         out_status
);
  import bfi_pkg::*;

  logic [7:0] prog_mem [PROG_DEPTH];
  logic [7:0] in_mem   [IN_DEPTH];
  logic [7:0] tape_mem [TAPE_CELLS];

  logic [TAPE_CELLS-1:0] tvalid_r;
  logic [PROG_CW-1:0]    plen_r, pc_r, q_r, depth_r;
  logic [IN_CW-1:0]      ilen_r, ip_r;
  logic [TAPE_AW-1:0]    tp_r;
  logic [OUT_CW-1:0]     ocount_r;
  logic [31:0]           steps_r;
  logic [7:0]            prog_q_r, tape_q_r, in_q_r, pend_byte_r;
  logic                  tv_q_r, pend_r;
  logic                  strobe_r, has_r, last_r;
  logic [7:0]            obyte_r;
  logic [1:0]            ostat_r;

  logic [PROG_AW-1:0] prog_raddr;
  logic [7:0]         cur_cell;
  logic [7:0]         cell_wdata;
  logic               cell_we;
  ch_t                cls;

  assign cur_cell = tv_q_r ? tape_q_r : 8'd0;
  assign cls      = classify(prog_q_r);

  always_comb begin
    case (cmd.op)
      OP_SF_RD: prog_raddr = q_r[PROG_AW-1:0];
      OP_SB_RD: prog_raddr = PROG_AW'(q_r - PROG_CW'(1));
      default:  prog_raddr = pc_r[PROG_AW-1:0];
    endcase
  end

  always_comb begin
    cell_we    = 1'b0;
    cell_wdata = cur_cell;
    if (cmd.op == OP_EXEC) begin
      case (cls)
        CH_INC: begin
          cell_we    = 1'b1;
          cell_wdata = cur_cell + 8'd1;
        end
        CH_DEC: begin
          cell_we    = 1'b1;
          cell_wdata = cur_cell - 8'd1;
        end
        CH_IN: begin
          cell_we    = 1'b1;
          cell_wdata = (ip_r < ilen_r) ? in_q_r : 8'd0;
        end
        default: cell_we = 1'b0;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && func == FN_LOAD_PROG && plen_r < PROG_CW'(PROG_DEPTH)) begin
      prog_mem[plen_r[PROG_AW-1:0]] <= data_byte;
    end
    if (cmd.op == OP_FETCH || cmd.op == OP_SF_RD || cmd.op == OP_SB_RD) begin
      prog_q_r <= prog_mem[prog_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && func == FN_LOAD_IN && ilen_r < IN_CW'(IN_DEPTH)) begin
      in_mem[IN_AW'(ilen_r)] <= data_byte;
    end
    if (cmd.op == OP_FETCH) begin
      in_q_r <= in_mem[IN_AW'(ip_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      tape_mem[tp_r] <= cell_wdata;
    end
    if (cmd.op == OP_FETCH) begin
      tape_q_r <= tape_mem[tp_r];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= '0;
      plen_r   <= '0;
      ilen_r   <= '0;
      pc_r     <= '0;
      q_r      <= '0;
      depth_r  <= '0;
      ip_r     <= '0;
      tp_r     <= '0;
      ocount_r <= '0;
      steps_r  <= '0;
      pend_r   <= 1'b0;
      tv_q_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      // the held byte goes out at the next '.' or at the end of the run
      strobe_r <= (cmd.op == OP_FINISH) || (cmd.op == OP_EXEC && cls == CH_OUT && pend_r);
      if (cell_we) begin
        tvalid_r[tp_r] <= 1'b1;
      end
      case (cmd.op)
        OP_LOAD: begin
          if (func == FN_LOAD_PROG && plen_r < PROG_CW'(PROG_DEPTH)) begin
            plen_r <= plen_r + PROG_CW'(1);
          end
          if (func == FN_LOAD_IN && ilen_r < IN_CW'(IN_DEPTH)) begin
            ilen_r <= ilen_r + IN_CW'(1);
          end
        end
        OP_START: begin
          tvalid_r <= '0;
          pc_r     <= '0;
          ip_r     <= '0;
          tp_r     <= '0;
          ocount_r <= '0;
          steps_r  <= '0;
          pend_r   <= 1'b0;
        end
        OP_FETCH: begin
          tv_q_r <= tvalid_r[tp_r];
        end
        OP_EXEC: begin
          steps_r <= steps_r + 32'd1;
          case (cls)
            CH_RIGHT: begin
              tp_r <= (tp_r == TAPE_AW'(TAPE_CELLS - 1)) ? '0 : tp_r + TAPE_AW'(1);
              pc_r <= pc_r + PROG_CW'(1);
            end
            CH_LEFT: begin
              tp_r <= (tp_r == '0) ? TAPE_AW'(TAPE_CELLS - 1) : tp_r - TAPE_AW'(1);
              pc_r <= pc_r + PROG_CW'(1);
            end
            CH_OUT: begin
              // the new byte waits to learn if it is last
              pend_r   <= 1'b1;
              ocount_r <= ocount_r + OUT_CW'(1);
              pc_r     <= pc_r + PROG_CW'(1);
            end
            CH_IN: begin
              if (ip_r < ilen_r) begin
                ip_r <= ip_r + IN_CW'(1);
              end
              pc_r <= pc_r + PROG_CW'(1);
            end
            CH_OPEN: begin
              if (cur_cell == 8'd0) begin
                q_r     <= pc_r + PROG_CW'(1);
                depth_r <= '0;
              end else begin
                pc_r <= pc_r + PROG_CW'(1);
              end
            end
            CH_CLOSE: begin
              if (cur_cell != 8'd0) begin
                q_r     <= pc_r;
                depth_r <= '0;
              end else begin
                pc_r <= pc_r + PROG_CW'(1);
              end
            end
            default: pc_r <= pc_r + PROG_CW'(1);
          endcase
        end
        OP_SF_CHK: begin
          if (cls == CH_OPEN) begin
            depth_r <= depth_r + PROG_CW'(1);
            q_r     <= q_r + PROG_CW'(1);
          end else if (cls == CH_CLOSE) begin
            if (depth_r == '0) begin
              pc_r <= q_r + PROG_CW'(1);
            end else begin
              depth_r <= depth_r - PROG_CW'(1);
              q_r     <= q_r + PROG_CW'(1);
            end
          end else begin
            q_r <= q_r + PROG_CW'(1);
          end
        end
        OP_SB_RD: begin
          q_r <= q_r - PROG_CW'(1);
        end
        OP_SB_CHK: begin
          if (cls == CH_CLOSE) begin
            depth_r <= depth_r + PROG_CW'(1);
          end else if (cls == CH_OPEN) begin
            if (depth_r == '0) begin
              pc_r <= q_r + PROG_CW'(1);
            end else begin
              depth_r <= depth_r - PROG_CW'(1);
            end
          end
        end
        OP_FINISH: begin
          pend_r <= 1'b0;
          plen_r <= '0;
          ilen_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EXEC && cls == CH_OUT) begin
      pend_byte_r <= cur_cell;
      has_r       <= 1'b1;
      obyte_r     <= pend_byte_r;
      last_r      <= 1'b0;
      ostat_r     <= ST_OK;
    end else if (cmd.op == OP_FINISH) begin
      has_r   <= pend_r;
      obyte_r <= pend_r ? pend_byte_r : 8'd0;
      last_r  <= 1'b1;
      ostat_r <= cmd.status;
    end
  end

  assign sts.cls        = cls;
  assign sts.cell_zero  = (cur_cell == 8'd0);
  assign sts.pc_end     = (pc_r >= plen_r);
  assign sts.steps_hit  = (steps_r >= step_limit);
  assign sts.out_full   = (ocount_r >= OUT_CW'(OUT_MAX));
  assign sts.depth_zero = (depth_r == '0);
  assign sts.q_end      = (q_r >= plen_r);
  assign sts.q_zero     = (q_r == '0);

  assign out_strobe   = strobe_r;
  assign out_has_byte = has_r;
  assign out_out_byte = obyte_r;
  assign out_last     = last_r;
  assign out_status   = ostat_r;

endmodule
`default_nettype wire

@@ sv/brainfuck_interpreter_core.sv @@
// Top level of the brainfuck interpreter core: APB step limit register,
// sequencer (bfi_ctrl) and datapath (bfi_datapath). Depends on bfi_pkg.
`default_nettype none
// Load requests (func 0 program byte, func 1 input byte) store one byte each;
// bytes beyond a store's capacity are dropped. A run request keeps busy high
// until interpretation ends: the sequencer passes each executed command
// through a fetch state (program/tape memory read) and an execute state, and
// each program position examined by a bracket scan through a read state and
// a check state. A run that reaches the end of its program, one stopped by
// the step limit or truncation, and one whose scan finds no partner all wrap
// up in the done state. The tape is cleared at once by per-cell valid bits.
// Each output byte is held until the next '.' or the end of the run, then
// appears on out_strobe for a single cycle and cannot be stalled; the final
// result, in the cycle busy drops, has out_last set and carries out_status.
module brainfuck_interpreter_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_strobe,
  output logic             out_has_byte,
  output logic [7:0]       out_out_byte,
  output logic             out_last,
  output logic [1:0]       out_status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bfi_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] step_limit_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_limit_r <= 32'd1000000;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      step_limit_r <= pwdata;
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? step_limit_r : 32'd0;

  bfi_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bfi_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .func         (in_func),
    .data_byte    (in_data_byte),
    .step_limit   (step_limit_r),
    .sts          (sts),
    .out_strobe   (out_strobe),
    .out_has_byte (out_has_byte),
    .out_out_byte (out_out_byte),
    .out_last     (out_last),
    .out_status   (out_status)
  );

endmodule
`default_nettype wire
